/* rtl/csem_pkg.sv */
// Shared constants and types for the counting semaphore with waiter queue.
`default_nettype none
package csem_pkg;

    localparam int QUEUE_DEPTH    = 16;
    localparam int THREAD_ID_BITS = 8;

    localparam int Q_ADDR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int Q_CNT_BITS  = $clog2(QUEUE_DEPTH + 1);
    localparam int Q_SUM_BITS  = Q_CNT_BITS + 1;

    localparam int OPCODE_BITS = 2;
    localparam int TID_BITS    = 8;
    localparam int STATUS_BITS = 3;
    localparam int UNITS_BITS  = 16;
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [OPCODE_BITS-1:0] OP_LOCK   = 2'd0;
    localparam logic [OPCODE_BITS-1:0] OP_TRY    = 2'd1;
    localparam logic [OPCODE_BITS-1:0] OP_UNLOCK = 2'd2;

    localparam logic [STATUS_BITS-1:0] ST_GRANTED  = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_REFUSED  = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_QUEUED   = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_IGNORED  = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_RELEASED = 3'd4;
    localparam logic [STATUS_BITS-1:0] ST_FULL     = 3'd5;

    localparam logic [CFG_IDX_BITS-1:0] CFG_START_UNITS = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_UNITS   = 1'b1;

    localparam logic [UNITS_BITS-1:0] UNITS_RESET = 16'd1;

    typedef struct packed {
        logic load_item;
        logic execute;
    } t_csem_cmd;

endpackage
`default_nettype wire

/* rtl/csem_ram.sv */
// Generic single-port-write, registered-read RAM.
`default_nettype none
module csem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_we,
    input  wire logic [ADDR_BITS-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0]        i_wdata,
    input  wire logic [ADDR_BITS-1:0]    i_raddr,
    output logic      [WIDTH-1:0]        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

/* rtl/csem_ctrl.sv */
// Controller: accept, execute and output handshake sequencing.
`default_nettype none
module csem_ctrl
    import csem_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_csem_cmd o_cmd
);
    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic in_ready, accept;

    assign in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign accept   = i_in_valid && in_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_state == S_EXEC) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready      = in_ready;
    assign o_out_valid     = r_out_valid;
    assign o_cmd.load_item = accept;
    assign o_cmd.execute   = (r_state == S_EXEC);

endmodule
`default_nettype wire

/* rtl/csem_dp.sv */
// Datapath: unit counter, waiter ring buffer and result registers.
`default_nettype none
module csem_dp
    import csem_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_csem_cmd                i_cmd,
    input  wire logic [OPCODE_BITS-1:0]   i_opcode,
    input  wire logic [TID_BITS-1:0]      i_thread_id,
    input  wire logic                     i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_BITS-1:0] i_cfg_data,
    output logic      [STATUS_BITS-1:0]   o_status,
    output logic                          o_wake_valid,
    output logic      [TID_BITS-1:0]      o_wake_thread,
    output logic      [UNITS_BITS-1:0]    o_units_now
);
    logic [OPCODE_BITS-1:0]    r_op;
    logic [THREAD_ID_BITS-1:0] r_tid;
    logic [UNITS_BITS-1:0]     r_count, n_count;
    logic [UNITS_BITS-1:0]     r_max;
    logic [Q_ADDR_BITS-1:0]    r_head, n_head;
    logic [Q_CNT_BITS-1:0]     r_wcnt, n_wcnt;
    logic [STATUS_BITS-1:0]    r_status, n_status;
    logic                      r_wake_valid, n_wake_valid;
    logic [TID_BITS-1:0]       r_wake_thread, n_wake_thread;

    logic                      q_full;
    logic                      q_push;
    logic [Q_SUM_BITS-1:0]     tail_sum;
    logic [Q_ADDR_BITS-1:0]    tail;
    logic [THREAD_ID_BITS-1:0] head_data;

    assign q_full   = (r_wcnt == Q_CNT_BITS'(QUEUE_DEPTH));
    assign tail_sum = Q_SUM_BITS'(r_head) + Q_SUM_BITS'(r_wcnt);
    assign tail     = (tail_sum >= Q_SUM_BITS'(QUEUE_DEPTH))
                    ? Q_ADDR_BITS'(tail_sum - Q_SUM_BITS'(QUEUE_DEPTH))
                    : Q_ADDR_BITS'(tail_sum);

    csem_ram #(
        .WIDTH (THREAD_ID_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_waiters (
        .i_clk   (i_clk),
        .i_we    (q_push),
        .i_waddr (tail),
        .i_wdata (r_tid),
        .i_raddr (r_head),
        .o_rdata (head_data)
    );

    always_comb begin
        n_count       = r_count;
        n_head        = r_head;
        n_wcnt        = r_wcnt;
        n_status      = ST_REFUSED;
        n_wake_valid  = 1'b0;
        n_wake_thread = '0;
        q_push        = 1'b0;
        case (r_op)
            OP_LOCK: begin
                if (r_count != '0) begin
                    n_count  = r_count - 1'b1;
                    n_status = ST_GRANTED;
                end else if (!q_full) begin
                    q_push   = i_cmd.execute;
                    n_wcnt   = r_wcnt + 1'b1;
                    n_status = ST_QUEUED;
                end else begin
                    n_status = ST_FULL;
                end
            end
            OP_TRY: begin
                if (r_count != '0) begin
                    n_count  = r_count - 1'b1;
                    n_status = ST_GRANTED;
                end
            end
            OP_UNLOCK: begin
                if (r_count >= r_max) begin
                    n_status = ST_IGNORED;
                end else begin
                    n_count  = r_count + 1'b1;
                    n_status = ST_RELEASED;
                    if (r_wcnt != '0) begin
                        n_wake_valid  = 1'b1;
                        n_wake_thread = TID_BITS'(head_data);
                        n_head = (r_head == Q_ADDR_BITS'(QUEUE_DEPTH - 1))
                               ? '0 : r_head + 1'b1;
                        n_wcnt = r_wcnt - 1'b1;
                    end
                end
            end
            default: begin
                n_status = ST_REFUSED;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= UNITS_RESET;
            r_max   <= UNITS_RESET;
            r_head  <= '0;
            r_wcnt  <= '0;
        end else if (i_cmd.execute) begin
            r_count <= n_count;
            r_head  <= n_head;
            r_wcnt  <= n_wcnt;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_START_UNITS) begin
                r_count <= UNITS_BITS'(i_cfg_data);
            end else begin
                r_max <= UNITS_BITS'(i_cfg_data);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_op  <= i_opcode;
            r_tid <= THREAD_ID_BITS'(i_thread_id);
        end
        if (i_cmd.execute) begin
            r_status      <= n_status;
            r_wake_valid  <= n_wake_valid;
            r_wake_thread <= n_wake_thread;
        end
    end

    assign o_status      = r_status;
    assign o_wake_valid  = r_wake_valid;
    assign o_wake_thread = r_wake_thread;
    assign o_units_now   = r_count;

endmodule
`default_nettype wire

/* rtl/counting_semaphore_fifo_waiters.sv */
// Top level of the counting semaphore with a FIFO of waiting thread IDs.
// Each request (lock, try-lock, unlock) produces one result transaction. A
// request is first captured and then evaluated against the unit counter and
// the waiter queue, whose head entry comes from a registered-read RAM; no new
// request is taken during the evaluation. The next request is accepted once
// the result register is free or is being drained that same cycle. The
// waiter queue holds QUEUE_DEPTH entries with no clearing pass after reset.
// Configuration writes load the unit count (start_units) or the upper limit
// (max_units) and are taken only while idle.
`default_nettype none
module counting_semaphore_fifo_waiters
    import csem_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output logic                          o_in_ready,
    input  wire logic [OPCODE_BITS-1:0]   i_opcode,
    input  wire logic [TID_BITS-1:0]      i_thread_id,
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output logic      [STATUS_BITS-1:0]   o_status,
    output logic                          o_wake_valid,
    output logic      [TID_BITS-1:0]      o_wake_thread,
    output logic      [UNITS_BITS-1:0]    o_units_now,
    input  wire logic                     i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_BITS-1:0] i_cfg_data
);
    t_csem_cmd cmd;

    csem_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    csem_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_opcode      (i_opcode),
        .i_thread_id   (i_thread_id),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_status      (o_status),
        .o_wake_valid  (o_wake_valid),
        .o_wake_thread (o_wake_thread),
        .o_units_now   (o_units_now)
    );

endmodule
`default_nettype wire

/* rtl/csem_checker.sv */
// Port-level checker for the counting semaphore, bound to the top level.
`default_nettype none
module csem_checker
    import csem_pkg::*;
(
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   i_in_valid,
    input wire logic                   o_in_ready,
    input wire logic                   o_out_valid,
    input wire logic                   i_out_ready,
    input wire logic [STATUS_BITS-1:0] o_status,
    input wire logic                   o_wake_valid,
    input wire logic [TID_BITS-1:0]    o_wake_thread
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status)
            && $stable(o_wake_valid) && $stable(o_wake_thread))
        else $error("result changed while stalled");

    a_no_accept_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input ready while result register is blocked");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second transaction accepted during evaluation");

    a_wake_only_on_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_wake_valid |-> o_status == ST_RELEASED)
        else $error("wake reported without release");

    a_no_wake_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_wake_valid |-> o_wake_thread == '0)
        else $error("wake id set without wake");

endmodule

bind counting_semaphore_fifo_waiters csem_checker u_csem_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_status      (o_status),
    .o_wake_valid  (o_wake_valid),
    .o_wake_thread (o_wake_thread)
);
`default_nettype wire

/* tb/sv/tb_csem_pkg.sv */
// Scoreboard class that predicts and checks the semaphore results.
`timescale 1ns / 1ps
package tb_csem_pkg;
    import csem_pkg::*;

    localparam logic [OPCODE_BITS-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic                   wake_valid;
        logic [TID_BITS-1:0]    wake_thread;
        logic [UNITS_BITS-1:0]  units_now;
    } sem_result_t;

    class semaphore_scoreboard;
        logic [UNITS_BITS-1:0] units      = UNITS_RESET;
        logic [UNITS_BITS-1:0] limit      = UNITS_RESET;
        logic [TID_BITS-1:0]   waiters [QUEUE_DEPTH];
        int                    wait_head  = 0;
        int                    wait_count = 0;
        sem_result_t           awaited [$];
        int                    checked    = 0;
        int                    errors     = 0;

        function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
            if (idx == CFG_START_UNITS) begin
                units = data;
            end else begin
                limit = data;
            end
        endfunction

        function void note_request(logic [OPCODE_BITS-1:0] op, logic [TID_BITS-1:0] tid);
            sem_result_t r;
            logic [TID_BITS-1:0] id;
            r.status      = ST_REFUSED;
            r.wake_valid  = 1'b0;
            r.wake_thread = '0;
            id = tid & TID_BITS'((32'd1 << THREAD_ID_BITS) - 1);
            case (op)
                OP_LOCK: begin
                    if (units != 0) begin
                        units--;
                        r.status = ST_GRANTED;
                    end else if (wait_count < QUEUE_DEPTH) begin
                        waiters[(wait_head + wait_count) % QUEUE_DEPTH] = id;
                        wait_count++;
                        r.status = ST_QUEUED;
                    end else begin
                        r.status = ST_FULL;
                    end
                end
                OP_TRY: begin
                    if (units != 0) begin
                        units--;
                        r.status = ST_GRANTED;
                    end
                end
                OP_UNLOCK: begin
                    if (units >= limit) begin
                        r.status = ST_IGNORED;
                    end else begin
                        units++;
                        if (wait_count != 0) begin
                            r.wake_valid  = 1'b1;
                            r.wake_thread = waiters[wait_head];
                            wait_head     = (wait_head + 1) % QUEUE_DEPTH;
                            wait_count--;
                        end
                        r.status = ST_RELEASED;
                    end
                end
                default: ;
            endcase
            r.units_now = units;
            awaited.push_back(r);
        endfunction

        task report_mismatch(string what, int got, int want);
            if (errors < 100) begin
                $display("%s at result %0d: got %0d, expected %0d", what, checked, got, want);
            end
            errors++;
        endtask

        task check_result(sem_result_t got);
            sem_result_t want;
            if (awaited.size() == 0) begin
                report_mismatch("result with none awaited", got.status, 0);
                return;
            end
            want = awaited.pop_front();
            if (got.status != want.status)
                report_mismatch("status", got.status, want.status);
            if (got.wake_valid != want.wake_valid)
                report_mismatch("wake_valid", got.wake_valid, want.wake_valid);
            if (got.wake_thread != want.wake_thread)
                report_mismatch("wake_thread", got.wake_thread, want.wake_thread);
            if (got.units_now != want.units_now)
                report_mismatch("units_now", got.units_now, want.units_now);
            checked++;
        endtask
    endclass

endpackage

/* tb/sv/tb_counting_semaphore_fifo_waiters.sv */
// Testbench top for the counting semaphore with a FIFO of waiting threads.
`timescale 1ns / 1ps
module tb_counting_semaphore_fifo_waiters;
    import csem_pkg::*;
    import tb_csem_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_in_valid;
    logic                     o_in_ready;
    logic [OPCODE_BITS-1:0]   i_opcode;
    logic [TID_BITS-1:0]      i_thread_id;
    logic                     o_out_valid;
    logic                     i_out_ready;
    logic [STATUS_BITS-1:0]   o_status;
    logic                     o_wake_valid;
    logic [TID_BITS-1:0]      o_wake_thread;
    logic [UNITS_BITS-1:0]    o_units_now;
    logic                     i_cfg_we;
    logic [CFG_IDX_BITS-1:0]  i_cfg_idx;
    logic [CFG_DATA_BITS-1:0] i_cfg_data;

    semaphore_scoreboard sb = new();
    int cycles;
    bit quiet_tail;
    bit send_calm;
    bit recv_calm;

    counting_semaphore_fifo_waiters DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_opcode      (i_opcode),
        .i_thread_id   (i_thread_id),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_wake_valid  (o_wake_valid),
        .o_wake_thread (o_wake_thread),
        .o_units_now   (o_units_now),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            sb.note_request(i_opcode, i_thread_id);
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_result({o_status, o_wake_valid, o_wake_thread, o_units_now});
        end
    end

    initial begin
        int stall_left;
        stall_left  = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 59) == 0) recv_calm = !recv_calm;
            if (stall_left == 0 && !quiet_tail && !recv_calm && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 12);
            if (stall_left != 0) begin
                i_out_ready = 1'b0;
                stall_left--;
            end else begin
                i_out_ready = 1'b1;
            end
        end
    end

    task automatic send_request(input logic [OPCODE_BITS-1:0] op, input logic [TID_BITS-1:0] tid);
        if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
        if (!quiet_tail && !send_calm && $urandom_range(0, 4) == 0) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
        i_in_valid  = 1'b1;
        i_opcode    = op;
        i_thread_id = tid;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        i_in_valid = 1'b0;
        while (sb.awaited.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        wait_idle();
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic set_units(input logic [UNITS_BITS-1:0] start, input logic [UNITS_BITS-1:0] max);
        write_reg(CFG_START_UNITS, start);
        write_reg(CFG_MAX_UNITS, max);
    endtask

    task automatic send_random(input int count);
        int pick;
        logic [OPCODE_BITS-1:0] op;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) op = OP_LOCK;
            else if (pick < 60) op = OP_TRY;
            else if (pick < 95) op = OP_UNLOCK;
            else op = OP_UNUSED;
            send_request(op, TID_BITS'($urandom_range(0, (1 << TID_BITS) - 1)));
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_opcode    = OP_LOCK;
        i_thread_id = '0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = CFG_START_UNITS;
        i_cfg_data  = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_request(OP_UNLOCK, 8'h00);
        send_request(OP_LOCK, 8'hFF);
        send_request(OP_UNLOCK, 8'h00);
        send_request(OP_LOCK, 8'h00);
        send_request(OP_TRY, 8'hFF);
        send_request(OP_UNUSED, 8'h3C);
        for (int k = 0; k < QUEUE_DEPTH; k++) send_request(OP_LOCK, TID_BITS'(k * 15 + 15));
        send_request(OP_LOCK, 8'hC3);
        send_request(OP_UNLOCK, 8'h81);
        set_units(16'hFFFF, 16'h0000);
        send_request(OP_TRY, 8'h55);
        send_request(OP_UNLOCK, 8'hAA);
        set_units(16'hFFFE, 16'hFFFF);
        send_request(OP_UNLOCK, 8'h12);
        send_request(OP_UNLOCK, 8'hED);

        set_units(16'd0, 16'd3);
        send_random(130);
        set_units(16'd2, 16'd2);
        send_random(110);
        set_units(16'd0, 16'd0);
        send_random(60);
        set_units(16'hFFFF, 16'hFFFF);
        send_random(90);
        set_units(16'd100, 16'd20);
        send_random(110);
        set_units(16'd1, 16'd8);
        send_random(70);
        quiet_tail = 1'b1;
        send_random(80);

        wait_idle();
        if (sb.errors == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end

endmodule

/* counting_semaphore_fifo_waiters.f */
rtl/csem_pkg.sv
rtl/csem_ram.sv
rtl/csem_ctrl.sv
rtl/csem_dp.sv
rtl/counting_semaphore_fifo_waiters.sv
rtl/csem_checker.sv
tb/sv/tb_csem_pkg.sv
tb/sv/tb_counting_semaphore_fifo_waiters.sv
